FILE: design/tequ_pkg.sv
`timescale 1ns / 1ps

package tequ_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned TimeBits = 32;
  localparam int unsigned TagBits  = 16;
  localparam int unsigned CntBits  = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    KIND_SCHEDULE = 2'd0,
    KIND_FIRE     = 2'd1,
    KIND_RUN      = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STAT_FIRED   = 3'd0,
    STAT_DONE    = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_BAD_ARG = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } cell_op_e;

  typedef struct packed {
    kind_e              kind;
    logic [15:0]        event_tag;
    logic signed [31:0] delay;
    logic [31:0]        target_time;
  } in_word_t;

  typedef struct packed {
    logic [15:0] event_tag_res;
    logic [31:0] current_time;
    status_e     status;
    logic [5:0]  pending_count;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic                valid;
    logic [TimeBits-1:0] due;
    logic [TagBits-1:0]  tag;
  } entry_t;

  typedef struct packed {
    cell_op_e            op;
    logic [TimeBits-1:0] due;
    logic [TagBits-1:0]  tag;
  } cell_cmd_t;

endpackage

FILE: design/timed_event_queue_unit.sv
`timescale 1ns / 1ps

// Event scheduler built as a sorted row of 32 cells, earliest due time at the
// head and equal due times kept in insertion order. On a schedule every cell
// compares its due time with the new one and shifts toward the tail, and on a
// fire the whole row shifts toward the head, in a single step.
// A run-until gives one result per cycle while the output is not stalled:
// one for each event it fires plus the closing word, and stalls the input.
// Results wait in one output register; a stalled output stalls the input.
// In the cells only the valid bits are reset.
module timed_event_queue_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tequ_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tequ_pkg::out_word_t out_word_o
);
  import tequ_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e              state_q, state_d;
  logic [TimeBits-1:0] now_q, now_d;
  logic [TimeBits-1:0] target_q, target_d;
  logic [CntBits-1:0]  count_q, count_d;
  out_word_t           out_q, res;
  logic                out_valid_q;
  logic                produce;

  cell_cmd_t           cmd;
  entry_t              entries [Capacity];
  logic                after   [Capacity];
  entry_t              head;

  logic                out_free;
  logic                in_acc;
  logic [TimeBits:0]   due_sum;
  logic                sched_bad;
  logic                full;

  genvar gi;
  generate
    for (gi = 0; gi < Capacity; gi++) begin : g_cell
      entry_t left_e, right_e;
      logic   left_after;
      if (gi == 0) begin : g_first
        assign left_e     = '0;
        assign left_after = 1'b0;
      end else begin : g_mid
        assign left_e     = entries[gi-1];
        assign left_after = after[gi-1];
      end
      if (gi == Capacity - 1) begin : g_last
        assign right_e = '0;
      end else begin : g_inner
        assign right_e = entries[gi+1];
      end
      tequ_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .cmd_i       (cmd),
        .left_i      (left_e),
        .left_after_i(left_after),
        .right_i     (right_e),
        .entry_o     (entries[gi]),
        .after_o     (after[gi])
      );
    end
  endgenerate

  assign head     = entries[0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc   = in_valid_i && !in_stall_o;

  assign due_sum   = {1'b0, now_q} + {1'b0, in_word_i.delay};
  assign sched_bad = in_word_i.delay[31] || due_sum[TimeBits];
  assign full      = (count_q == CntBits'(Capacity));

  always_comb begin
    state_d  = state_q;
    now_d    = now_q;
    target_d = target_q;
    count_d  = count_q;
    produce  = 1'b0;
    cmd      = '{op: OP_HOLD, due: due_sum[TimeBits-1:0], tag: in_word_i.event_tag};
    res      = '{event_tag_res: '0, current_time: now_q, status: STAT_BAD_ARG,
                 pending_count: count_q, last: 1'b1};
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_word_i.kind)
            KIND_SCHEDULE: begin
              produce = 1'b1;
              if (sched_bad) begin
                res.status = STAT_BAD_ARG;
              end else if (full) begin
                res.status = STAT_FULL;
              end else begin
                cmd.op     = OP_INSERT;
                count_d    = count_q + 1'b1;
                res.status = STAT_DONE;
              end
            end
            KIND_FIRE: begin
              produce = 1'b1;
              if (!head.valid) begin
                res.status = STAT_EMPTY;
              end else begin
                cmd.op            = OP_POP;
                now_d             = head.due;
                count_d           = count_q - 1'b1;
                res.status        = STAT_FIRED;
                res.event_tag_res = head.tag;
              end
            end
            KIND_RUN: begin
              if (in_word_i.target_time < now_q) begin
                produce    = 1'b1;
                res.status = STAT_BAD_ARG;
              end else begin
                target_d = in_word_i.target_time;
                state_d  = S_RUN;
              end
            end
            default: begin
              produce    = 1'b1;
              res.status = STAT_BAD_ARG;
            end
          endcase
        end
      end
      S_RUN: begin
        if (out_free) begin
          produce = 1'b1;
          if (head.valid && (head.due < target_q)) begin
            cmd.op            = OP_POP;
            now_d             = head.due;
            count_d           = count_q - 1'b1;
            res.status        = STAT_FIRED;
            res.event_tag_res = head.tag;
            res.last          = 1'b0;
          end else begin
            now_d      = target_q;
            res.status = STAT_DONE;
            state_d    = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    res.current_time  = now_d;
    res.pending_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      target_q    <= '0;
      count_q     <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      now_q    <= now_d;
      target_q <= target_d;
      count_q  <= count_d;
      if (produce) begin
        out_q       <= res;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: design/tequ_cell.sv
`timescale 1ns / 1ps

module tequ_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tequ_pkg::cell_cmd_t cmd_i,
  input  tequ_pkg::entry_t   left_i,
  input  logic               left_after_i,
  input  tequ_pkg::entry_t   right_i,
  output tequ_pkg::entry_t   entry_o,
  output logic               after_o
);
  import tequ_pkg::*;

  logic                valid_q, valid_d;
  logic [TimeBits-1:0] due_q, due_d;
  logic [TagBits-1:0]  tag_q, tag_d;
  logic                load;

  // new entry belongs in front of this cell; equal due times stay behind
  assign after_o = !valid_q || (due_q > cmd_i.due);

  always_comb begin
    valid_d = valid_q;
    due_d   = due_q;
    tag_d   = tag_q;
    load    = 1'b0;
    case (cmd_i.op)
      OP_INSERT: begin
        if (left_after_i) begin
          valid_d = left_i.valid;
          due_d   = left_i.due;
          tag_d   = left_i.tag;
          load    = 1'b1;
        end else if (after_o) begin
          valid_d = 1'b1;
          due_d   = cmd_i.due;
          tag_d   = cmd_i.tag;
          load    = 1'b1;
        end
      end
      OP_POP: begin
        valid_d = right_i.valid;
        due_d   = right_i.due;
        tag_d   = right_i.tag;
        load    = 1'b1;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      due_q <= due_d;
      tag_q <= tag_d;
    end
  end

  assign entry_o = '{valid: valid_q, due: due_q, tag: tag_q};

endmodule

FILE: design/tequ_checker.sv
`timescale 1ns / 1ps

module tequ_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input tequ_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input tequ_pkg::out_word_t out_word_o
);
  import tequ_pkg::*;

  // a stalled result word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // while a run-until is still firing, no new input word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.last |-> in_stall_o)
    else $error("input taken in the middle of a run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.pending_count <= 6'(Capacity))
    else $error("pending count above capacity");

  // only fired events carry a tag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != STAT_FIRED) |-> out_word_o.event_tag_res == '0)
    else $error("tag on a result that fired nothing");

endmodule

bind timed_event_queue_unit tequ_checker u_tequ_checker (.*);
